[rtl/core/csv_record_field_tokenizer_top_assert.svh]
// ----------------------------------------------------------------------------
// csv_record_field_tokenizer_top_assert.svh
// Assertion macros for the CSV record field tokenizer.
// ----------------------------------------------------------------------------
`ifndef CSV_RECORD_FIELD_TOKENIZER_TOP_ASSERT_SVH
`define CSV_RECORD_FIELD_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CSVTOK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CSVTOK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/csvtok_pkg.sv]
// ----------------------------------------------------------------------------
// csvtok_pkg
// Types and constants shared by the CSV record field tokenizer.
// ----------------------------------------------------------------------------
package csvtok_pkg;

    localparam int MAX_FIELDS  = 32;
    localparam int STORE_BYTES = 512;

    localparam int USED_W  = $clog2(STORE_BYTES);
    localparam int FOPEN_W = $clog2(MAX_FIELDS + 1);
    localparam int IDX_W   = 5;
    localparam int TOTAL_W = 6;
    localparam int BYTE_W  = 8;

    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef enum logic [1:0] {
        MODE_UNQUOTED = 2'd0,
        MODE_QUOTED   = 2'd1,
        MODE_PENDING  = 2'd2
    } t_mode;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] in_byte;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [IDX_W-1:0]   field_index;
        logic               is_field_end;
        logic               is_record_end;
        logic               record_error;
        logic [TOTAL_W-1:0] total_fields;
    } t_result;

endpackage

[rtl/core/csvtok_in_stage.sv]
// ----------------------------------------------------------------------------
// csvtok_in_stage
// Input register: holds one accepted beat until the scanner consumes it.
// ----------------------------------------------------------------------------
module csvtok_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  csvtok_pkg::t_item   i_item,
    input  logic                i_advance,
    output logic                o_valid,
    output csvtok_pkg::t_item   o_item
);

    logic              r_valid;
    csvtok_pkg::t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

[rtl/core/csvtok_scan.sv]
// ----------------------------------------------------------------------------
// csvtok_scan
// Quote-mode tracker, store and field counters, and result decode.
// ----------------------------------------------------------------------------
module csvtok_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  csvtok_pkg::t_item   i_item,
    output logic                o_res_valid,
    output csvtok_pkg::t_result o_res
);

    csvtok_pkg::t_mode                 r_mode, n_mode;
    logic [csvtok_pkg::USED_W-1:0]     r_used, n_used;
    logic [csvtok_pkg::FOPEN_W-1:0]    r_fopen, n_fopen;
    logic                              r_err, n_err;
    logic                              r_stop, n_stop;

    logic                              room;
    logic                              fields_full;
    logic                              is_quote;
    logic                              is_comma;
    logic                              is_eol;
    logic                              live;
    logic [csvtok_pkg::IDX_W-1:0]      cur_idx;

    assign room        = r_used < csvtok_pkg::USED_W'(csvtok_pkg::STORE_BYTES - 1);
    assign fields_full = r_fopen >= csvtok_pkg::FOPEN_W'(csvtok_pkg::MAX_FIELDS);
    assign is_quote    = i_item.in_byte == csvtok_pkg::CH_QUOTE;
    assign is_comma    = i_item.in_byte == csvtok_pkg::CH_COMMA;
    assign is_eol      = (i_item.in_byte == csvtok_pkg::CH_CR) ||
                         (i_item.in_byte == csvtok_pkg::CH_LF);
    assign live        = (i_item.op == csvtok_pkg::OP_DATA) && !r_err && !r_stop;
    assign cur_idx     = csvtok_pkg::IDX_W'(r_fopen - csvtok_pkg::FOPEN_W'(1));

    // next mode
    always_comb begin
        n_mode = r_mode;
        if (i_item.op == csvtok_pkg::OP_END) begin
            n_mode = csvtok_pkg::MODE_UNQUOTED;
        end else if (live) begin
            case (r_mode)
                csvtok_pkg::MODE_QUOTED: begin
                    n_mode = is_quote ? csvtok_pkg::MODE_PENDING : csvtok_pkg::MODE_QUOTED;
                end
                default: begin
                    // pending with a quote is an escaped quote; otherwise unquoted
                    n_mode = is_quote ? csvtok_pkg::MODE_QUOTED : csvtok_pkg::MODE_UNQUOTED;
                end
            endcase
        end
    end

    // counters, flags and result
    always_comb begin
        n_used      = r_used;
        n_fopen     = r_fopen;
        n_err       = r_err;
        n_stop      = r_stop;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_item.op == csvtok_pkg::OP_END) begin
            o_res_valid         = 1'b1;
            o_res.is_record_end = 1'b1;
            if (r_err || !room) begin
                o_res.record_error = 1'b1;
            end else begin
                o_res.is_field_end = 1'b1;
                o_res.field_index  = cur_idx;
                o_res.total_fields = csvtok_pkg::TOTAL_W'(r_fopen);
            end
            n_used  = '0;
            n_fopen = csvtok_pkg::FOPEN_W'(1);
            n_err   = 1'b0;
            n_stop  = 1'b0;
        end else if (live) begin
            if (r_mode == csvtok_pkg::MODE_QUOTED ||
                (r_mode == csvtok_pkg::MODE_PENDING && is_quote)) begin
                if (r_mode == csvtok_pkg::MODE_PENDING || !is_quote) begin
                    if (room) begin
                        n_used            = r_used + csvtok_pkg::USED_W'(1);
                        o_res_valid       = 1'b1;
                        o_res.out_byte    = i_item.in_byte;
                        o_res.field_index = cur_idx;
                    end else begin
                        n_err = 1'b1;
                    end
                end
            end else if (is_quote) begin
                n_err = r_err;
            end else if (is_comma) begin
                if (!room || fields_full) begin
                    n_err = 1'b1;
                end else begin
                    n_used             = r_used + csvtok_pkg::USED_W'(1);
                    n_fopen            = r_fopen + csvtok_pkg::FOPEN_W'(1);
                    o_res_valid        = 1'b1;
                    o_res.field_index  = cur_idx;
                    o_res.is_field_end = 1'b1;
                end
            end else if (is_eol) begin
                n_stop = 1'b1;
            end else if (room) begin
                n_used            = r_used + csvtok_pkg::USED_W'(1);
                o_res_valid       = 1'b1;
                o_res.out_byte    = i_item.in_byte;
                o_res.field_index = cur_idx;
            end else begin
                n_err = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= csvtok_pkg::MODE_UNQUOTED;
            r_used  <= '0;
            r_fopen <= csvtok_pkg::FOPEN_W'(1);
            r_err   <= 1'b0;
            r_stop  <= 1'b0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_used  <= n_used;
            r_fopen <= n_fopen;
            r_err   <= n_err;
            r_stop  <= n_stop;
        end
    end

endmodule

[rtl/core/csvtok_out_stage.sv]
// ----------------------------------------------------------------------------
// csvtok_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module csvtok_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  csvtok_pkg::t_result i_res,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output csvtok_pkg::t_result o_res
);

    logic                r_valid;
    csvtok_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

[rtl/core/csv_record_field_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// csv_record_field_tokenizer_top
// Streaming CSV record tokenizer with quote handling and record summary.
// ----------------------------------------------------------------------------
// One byte or end-of-record beat is taken every cycle while the sink keeps up.
// Each beat passes an input register, the quote-mode and counter logic, and a
// result register, which loads when the scanner consumes the beat; beats that
// make no result (quotes, bytes after CR/LF or after an error) leave no gap.
// While a result waits on a stalled sink, the input register takes one more
// beat and then holds tready low until the result drains. No clearing pass
// after reset.
module csv_record_field_tokenizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  logic        i_s_axis_tuser,   // [0] op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] out_byte, [12:8] field_index,
                                          // [18:13] total_fields, [23:19] zero
    output logic [1:0]  o_m_axis_tuser,   // [0] is_field_end, [1] record_error
    output logic        o_m_axis_tlast    // is_record_end
);

    csvtok_pkg::t_item   in_item;
    csvtok_pkg::t_item   stage_item;
    csvtok_pkg::t_result scan_res;
    csvtok_pkg::t_result out_res;
    logic                stage_valid;
    logic                out_free;
    logic                step;
    logic                res_valid;

    assign in_item.op      = i_s_axis_tuser;
    assign in_item.in_byte = i_s_axis_tdata;
    assign step            = stage_valid && out_free;

    csvtok_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (in_item),
        .i_advance (out_free),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    csvtok_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (stage_item),
        .o_res_valid (res_valid),
        .o_res       (scan_res)
    );

    csvtok_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res_valid),
        .i_res   (scan_res),
        .o_free  (out_free),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (out_res)
    );

    assign o_m_axis_tdata = {5'd0, out_res.total_fields, out_res.field_index,
                             out_res.out_byte};
    assign o_m_axis_tuser = {out_res.record_error, out_res.is_field_end};
    assign o_m_axis_tlast = out_res.is_record_end;

`include "csv_record_field_tokenizer_top_assert.svh"

    `CSVTOK_ASSERT_NOW(a_err_only_at_end, o_m_axis_tvalid && o_m_axis_tuser[1], o_m_axis_tlast && !o_m_axis_tuser[0] && (o_m_axis_tdata[18:13] == 6'd0), "error flag off a clean record end")
    `CSVTOK_ASSERT_NOW(a_end_has_count, o_m_axis_tvalid && o_m_axis_tlast && !o_m_axis_tuser[1], o_m_axis_tuser[0] && (o_m_axis_tdata[18:13] != 6'd0), "record end without field count")
    `CSVTOK_ASSERT_NOW(a_count_only_at_end, o_m_axis_tvalid && !o_m_axis_tlast, o_m_axis_tdata[18:13] == 6'd0, "field count on a non-final beat")
    `CSVTOK_ASSERT_NEXT(a_stalled_stage_holds, stage_valid && !out_free, stage_valid && $stable(stage_item), "input stage lost a beat under stall")

endmodule
